/* hdl/fnsrb_pkg.sv */
// ============================================================================
// fnsrb_pkg : shared types and constants for the fractional-N register builder
// Holds field widths, frequency limits, status codes, CSR indices and the divider select.
// ============================================================================
package fnsrb_pkg;

   localparam int unsigned FreqW  = 23;
   localparam int unsigned SpW    = 17;
   localparam int unsigned RefW   = 18;
   localparam int unsigned PnW    = 19;   // ref * (1 + doubler)
   localparam int unsigned PdW    = 9;    // rdiv * (1 + halver)
   localparam int unsigned VcoW   = 23;
   localparam int unsigned NumW   = VcoW + PdW;        // 32
   localparam int unsigned ModW   = 12;
   localparam int unsigned DenW   = PdW + SpW;         // 26

   localparam logic [FreqW-1:0] FreqMin = 23'd35000;
   localparam logic [FreqW-1:0] FreqMax = 23'd4400000;
   localparam logic [FreqW+5:0] VcoMin  = 29'd2200000;
   localparam logic [FreqW+5:0] VcoMax  = 29'd4400000;
   localparam logic [ModW-1:0]  ModMax  = 12'd4095;
   localparam logic [15:0]      PreLimit = 16'd75;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FREQ = 2'd1,
      ST_VCO  = 2'd2,
      ST_MOD  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_REF    = 3'd0,
      CSR_RDIV   = 3'd1,
      CSR_DBL    = 3'd2,
      CSR_HALF   = 3'd3,
      CSR_POWER  = 3'd4,
      CSR_RFON   = 3'd5,
      CSR_PUMP   = 3'd6
   } csr_index_type;

   // Pick the output divider select from the threshold chain.
   function automatic logic [2:0] div_sel(input logic [FreqW-1:0] f);
      logic [2:0] s;
      begin
         if (f >= 23'd2200000) s = 3'd0;
         else if (f >= 23'd1100000) s = 3'd1;
         else if (f >= 23'd550000) s = 3'd2;
         else if (f >= 23'd275000) s = 3'd3;
         else if (f >= 23'd137500) s = 3'd4;
         else if (f >= 23'd68750) s = 3'd5;
         else s = 3'd6;
         return s;
      end
   endfunction

endpackage

/* hdl/fnsrb_divider.sv */
// ============================================================================
// fnsrb_divider : pipelined restoring divider
// One quotient bit per stage; an item enters each cycle while adv is high, and stalls as a whole.
// ============================================================================
module fnsrb_divider
   import fnsrb_pkg::*;
#(
   parameter int unsigned NW = 32,
   parameter int unsigned DW = 32,
   parameter int unsigned TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [DW-1:0] out_rem,
   output logic [TW-1:0] out_tag
);

   logic          vld_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [TW-1:0] tag_ff [NW];

   // One trial subtract per stage, shifting quotient bits in from the right.
   for (genvar g = 0; g < NW; g++) begin : g_stage
      logic          vld_i;
      logic [NW-1:0] num_i;
      logic [DW-1:0] rem_i;
      logic [DW-1:0] den_i;
      logic [TW-1:0] tag_i;
      logic [DW:0]   trial;
      logic [DW:0]   diff;

      // Take the stage input from the ports or from the previous stage.
      if (g == 0) begin : g_head
         assign vld_i = in_valid;
         assign num_i = in_num;
         assign rem_i = '0;
         assign den_i = in_den;
         assign tag_i = in_tag;
      end else begin : g_body
         assign vld_i = vld_ff[g-1];
         assign num_i = num_ff[g-1];
         assign rem_i = rem_ff[g-1];
         assign den_i = den_ff[g-1];
         assign tag_i = tag_ff[g-1];
      end

      always_comb begin
         trial = {rem_i, num_i[NW-1]};
         diff  = trial - {1'b0, den_i};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (adv) begin
            vld_ff[g] <= vld_i;
         end
         if (adv) begin
            if (!diff[DW]) begin
               rem_ff[g] <= diff[DW-1:0];
               num_ff[g] <= {num_i[NW-2:0], 1'b1};
            end else begin
               rem_ff[g] <= trial[DW-1:0];
               num_ff[g] <= {num_i[NW-2:0], 1'b0};
            end
            den_ff[g] <= den_i;
            tag_ff[g] <= tag_i;
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = num_ff[NW-1];
   assign out_rem   = rem_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

/* hdl/frac_n_synth_register_builder_unit.sv */
// ============================================================================
// frac_n_synth_register_builder_unit : fractional-N PLL register word builder
// Computes divider, modulus, N and fraction, then emits six register words or one error word.
// ============================================================================
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | target_freq_khz, spacing_khz
//  rsp     | out       | rsp_valid/ready    | reg_word, reg_number, last_word, status
//  csr     | in        | csr_write_enable   | csr_index, csr_data (18 bits)
//
// An accepted request passes the stage 1 check register, three pipelined dividers
// (modulus 21, N 32, fraction 33 stages, one quotient bit a stage), the product
// register and the tail slot before its first word appears. An item may enter
// every cycle while the pipeline advances; the word emitter sends six words per
// ok item and one on an error, which sets the sustained rate. The pipeline
// advances only when its tail slot is free or handing over its last word; a stall
// freezes every stage. Reset clears valid bits and loads the register defaults.
module frac_n_synth_register_builder_unit
   import fnsrb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FreqW-1:0]  req_target_freq_khz,
   input  logic [SpW-1:0]    req_spacing_khz,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_reg_word,
   output logic [2:0]        rsp_reg_number,
   output logic              rsp_last_word,
   output logic [1:0]        rsp_status,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [RefW-1:0]   csr_data
);

   // Configuration registers.
   logic [RefW-1:0] ref_ff;
   logic [7:0]      rdiv_ff;
   logic            dbl_ff, half_ff, rfon_ff;
   logic [1:0]      pwr_ff;
   logic [3:0]      pump_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= 18'd25000; rdiv_ff <= 8'd1; dbl_ff <= 1'b0; half_ff <= 1'b0;
         pwr_ff <= 2'd3; rfon_ff <= 1'b1; pump_ff <= 4'd7;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REF:   ref_ff  <= csr_data;
            CSR_RDIV:  rdiv_ff <= csr_data[7:0];
            CSR_DBL:   dbl_ff  <= csr_data[0];
            CSR_HALF:  half_ff <= csr_data[0];
            CSR_POWER: pwr_ff  <= csr_data[1:0];
            CSR_RFON:  rfon_ff <= csr_data[0];
            CSR_PUMP:  pump_ff <= csr_data[3:0];
            default:   ;
         endcase
      end
   end

   logic [PnW-1:0] pn;
   logic [PdW-1:0] pd;
   logic [7:0]     rdiv_eff;
   assign pn       = dbl_ff ? {ref_ff, 1'b0} : {1'b0, ref_ff};
   assign rdiv_eff = (rdiv_ff == 8'd0) ? 8'd1 : rdiv_ff;
   assign pd       = half_ff ? {rdiv_eff, 1'b0} : {1'b0, rdiv_eff};

   // Global advance: tail slot free or being drained.
   logic adv;
   logic tail_busy;
   assign req_ready = adv;

   // Stage 1: range checks, divider select, VCO, products.
   logic        s1_vld_ff;
   logic [1:0]  s1_st_ff;
   logic [2:0]  s1_sel_ff;
   logic [VcoW-1:0] s1_vco_ff;
   logic [SpW-1:0]  s1_sp_ff;
   logic [DenW-1:0] s1_den_ff;

   logic [2:0]      sel_c;
   logic [FreqW+5:0] vco_wide;
   logic [1:0]      st_c;
   always_comb begin
      sel_c    = div_sel(req_target_freq_khz);
      vco_wide = {6'd0, req_target_freq_khz} << sel_c;
      if (req_target_freq_khz < FreqMin || req_target_freq_khz > FreqMax) st_c = ST_FREQ;
      else if (vco_wide < VcoMin || vco_wide > VcoMax) st_c = ST_VCO;
      else st_c = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= req_valid;
      if (adv) begin
         s1_st_ff  <= st_c;
         s1_sel_ff <= sel_c;
         s1_vco_ff <= vco_wide[VcoW-1:0];
         s1_sp_ff  <= req_spacing_khz;
         s1_den_ff <= pd * req_spacing_khz;
      end
   end

   // Stage 2: modulus division (2pn+den)/(2den) and N division vco*pd/pn.
   localparam int unsigned MnW = PnW + 2;        // 21
   localparam int unsigned MdW = DenW + 1;       // 27
   localparam int unsigned TagA = 2 + 3 + 1 + NumW;
   logic [MnW-1:0] mnum;
   logic [MdW-1:0] mden;
   assign mnum = {1'b0, pn, 1'b0} + MnW'(s1_den_ff);
   assign mden = {s1_den_ff, 1'b0};

   logic            ma_vld;
   logic [MnW-1:0]  ma_quo;
   logic [MdW-1:0]  ma_rem;
   logic [TagA-1:0] ma_tag;
   logic [NumW-1:0] num_c;
   assign num_c = s1_vco_ff * pd;

   fnsrb_divider #(.NW(MnW), .DW(MdW), .TW(TagA)) u_mod_div (
      .clock, .reset, .adv,
      .in_valid (s1_vld_ff),
      .in_num   (mnum),
      .in_den   (s1_sp_ff == '0 ? MdW'(1) : mden),
      .in_tag   ({s1_st_ff, s1_sel_ff, (s1_sp_ff == '0), num_c}),
      .out_valid(ma_vld), .out_quo(ma_quo), .out_rem(ma_rem), .out_tag(ma_tag)
   );

   // Clamp modulus and flag zero.
   logic [ModW-1:0] modv;
   logic            spz;
   logic [1:0]      st_m;
   assign spz  = ma_tag[NumW];
   assign modv = (spz || ma_quo > MnW'(ModMax)) ? ModMax : ma_quo[ModW-1:0];
   assign st_m = (ma_tag[TagA-1 -: 2] != ST_OK) ? ma_tag[TagA-1 -: 2]
               : (modv == '0) ? ST_MOD : ST_OK;

   // N division.
   localparam int unsigned TagB = 2 + 3 + ModW;
   logic            nb_vld;
   logic [NumW-1:0] nb_quo;
   logic [PnW-1:0]  nb_rem;
   logic [TagB-1:0] nb_tag;
   fnsrb_divider #(.NW(NumW), .DW(PnW), .TW(TagB)) u_n_div (
      .clock, .reset, .adv,
      .in_valid (ma_vld),
      .in_num   (ma_tag[NumW-1:0]),
      .in_den   (pn == '0 ? PnW'(1) : pn),
      .in_tag   ({st_m, ma_tag[TagA-3 -: 3], modv}),
      .out_valid(nb_vld), .out_quo(nb_quo), .out_rem(nb_rem), .out_tag(nb_tag)
   );

   // Register rem*modv before the fraction division.
   localparam int unsigned FnW = PnW + ModW + 2;   // 33
   logic            s3_vld_ff;
   logic [PnW+ModW-1:0] s3_prod_ff;
   logic [NumW-1:0] s3_n_ff;
   logic [TagB-1:0] s3_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (adv) s3_vld_ff <= nb_vld;
      if (adv) begin
         s3_prod_ff <= nb_rem * nb_tag[ModW-1:0];
         s3_n_ff    <= nb_quo;
         s3_tag_ff  <= nb_tag;
      end
   end

   localparam int unsigned TagC = TagB + 16;
   logic [FnW-1:0] fnum;
   assign fnum = {s3_prod_ff, 1'b0} + FnW'(pn);
   logic            fc_vld;
   logic [FnW-1:0]  fc_quo;
   logic [PnW:0]    fc_rem;
   logic [TagC-1:0] fc_tag;
   fnsrb_divider #(.NW(FnW), .DW(PnW+1), .TW(TagC)) u_f_div (
      .clock, .reset, .adv,
      .in_valid (s3_vld_ff),
      .in_num   (fnum),
      .in_den   (pn == '0 ? (PnW+1)'(2) : {pn, 1'b0}),
      .in_tag   ({s3_tag_ff, s3_n_ff[15:0]}),
      .out_valid(fc_vld), .out_quo(fc_quo), .out_rem(fc_rem), .out_tag(fc_tag)
   );

   // Carry: frac < 2*modv always holds, so one subtract suffices.
   logic [ModW-1:0] modf;
   logic [ModW-1:0] frac;
   logic [15:0]     n16;
   logic [FnW-1:0]  fq;
   assign modf = fc_tag[16 +: ModW];
   assign fq   = fc_quo;
   always_comb begin
      if (fq >= FnW'(modf)) begin
         frac = ModW'(fq - FnW'(modf));
         n16  = fc_tag[15:0] + 16'd1;
      end else begin
         frac = fq[ModW-1:0];
         n16  = fc_tag[15:0];
      end
   end

   // Tail slot: final parameters of one item, walked out as words.
   logic            t_vld_ff;
   logic [1:0]      t_st_ff;
   logic [2:0]      t_sel_ff;
   logic [ModW-1:0] t_mod_ff, t_frac_ff;
   logic [15:0]     t_n_ff;
   logic [2:0]      t_idx_ff;
   logic            done;

   assign tail_busy = t_vld_ff && !done;
   assign adv       = !tail_busy;
   assign done      = rsp_ready && (t_st_ff != ST_OK || t_idx_ff == 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (adv) begin
         t_vld_ff <= fc_vld;
      end
      if (adv) begin
         t_st_ff   <= fc_tag[TagC-1 -: 2];
         t_sel_ff  <= fc_tag[TagC-3 -: 3];
         t_mod_ff  <= modf;
         t_frac_ff <= frac;
         t_n_ff    <= n16;
         t_idx_ff  <= 3'd5;
      end else if (rsp_ready) begin
         t_idx_ff  <= t_idx_ff - 3'd1;
      end
   end

   // Pack the register word.
   logic lock, pre;
   assign lock = (t_frac_ff == '0);
   assign pre  = (t_n_ff >= PreLimit);
   always_comb begin
      case (t_idx_ff)
         3'd5: rsp_reg_word = 32'd5 | (32'd3 << 19) | (32'd1 << 22);
         3'd4: rsp_reg_word = 32'd4 | {27'd0, pwr_ff, 3'd0} | {26'd0, rfon_ff, 5'd0}
                            | (32'd200 << 12) | {9'd0, t_sel_ff, 20'd0} | (32'd1 << 23);
         3'd3: rsp_reg_word = 32'd3 | (32'd150 << 3);
         3'd2: rsp_reg_word = 32'd2 | (32'd1 << 6) | {23'd0, lock, lock, 7'd0}
                            | {19'd0, pump_ff, 9'd0} | {10'd0, rdiv_ff, 14'd0}
                            | {7'd0, half_ff, 24'd0} | {6'd0, dbl_ff, 25'd0};
         3'd1: rsp_reg_word = 32'd1 | {17'd0, t_mod_ff, 3'd0} | (32'd1 << 15)
                            | {4'd0, pre, 27'd0};
         default: rsp_reg_word = {1'b0, t_n_ff, 15'd0} | {17'd0, t_frac_ff, 3'd0};
      endcase
      if (t_st_ff != ST_OK) rsp_reg_word = '0;
   end

   assign rsp_valid      = t_vld_ff;
   assign rsp_reg_number = (t_st_ff != ST_OK) ? 3'd0 : t_idx_ff;
   assign rsp_last_word  = (t_st_ff != ST_OK) || (t_idx_ff == 3'd0);
   assign rsp_status     = t_st_ff;

   // Checks.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last_word && rsp_reg_word == 32'd0)
      else $error("error word malformed");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s1_vld_ff))
      else $error("pipeline moved during stall");
   a_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid
      && rsp_reg_number == $past(rsp_reg_number) - 3'd1)
      else $error("word sequence broken");

endmodule

/* tb/sv/frac_n_synth_register_builder_unit_test.sv */
// ============================================================================
// Register builder testbench
// Drives frequency/spacing words through the block under random handshake
// pressure, predicts the six register words (or the error word) per request
// and compares every result word in order, across several CSR settings.
// ============================================================================
module frac_n_synth_register_builder_unit_test
   import fnsrb_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [FreqW-1:0] freq;
      logic [SpW-1:0]   spacing;
   } freq_req_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  num;
      logic        last;
      logic [1:0]  status;
   } reg_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [FreqW-1:0] req_target_freq_khz = '0;
   logic [SpW-1:0] req_spacing_khz = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_reg_word;
   logic [2:0] rsp_reg_number;
   logic rsp_last_word;
   logic [1:0] rsp_status;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [RefW-1:0] csr_data = '0;

   frac_n_synth_register_builder_unit dut (.*);

   // shadow copy of the CSRs
   logic [17:0] m_ref;
   logic [7:0]  m_rdiv;
   logic        m_dbl, m_half, m_rfon;
   logic [1:0]  m_power;
   logic [3:0]  m_pump;

   freq_req_type pending_reqs[$];
   reg_word_type expected_words[$];
   int error_count = 0;
   int idle_cycles = 0;
   int hold_off = 0;
   int burst_left = 0;
   int gap_left = 0;
   bit stimulus_done = 0;
   bit long_stall_ask = 0;
   bit long_stall_taken = 0;
   localparam int WatchdogLimit = 20000;

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic reg_word_type make_word(logic [31:0] w, logic [2:0] n, logic l,
                                              status_type s);
      reg_word_type r;
      r.word = w; r.num = n; r.last = l; r.status = s;
      return r;
   endfunction

   // Compute the register words for one request and queue them.
   function automatic void predict_words(freq_req_type rq);
      logic [63:0] vco, pn, pd, modv, nint, rem, frac, num, den;
      logic [2:0] sel;
      logic [15:0] n16;
      logic pre, lock;
      logic [31:0] w [6];
      if (rq.freq < 35000 || rq.freq > 4400000) begin
         expected_words.push_back(make_word(0, 0, 1, ST_FREQ));
         return;
      end
      sel = 3'd6;
      if (rq.freq >= 2200000) sel = 0;
      else if (rq.freq >= 1100000) sel = 1;
      else if (rq.freq >= 550000) sel = 2;
      else if (rq.freq >= 275000) sel = 3;
      else if (rq.freq >= 137500) sel = 4;
      else if (rq.freq >= 68750) sel = 5;
      vco = 64'(rq.freq) << sel;
      if (vco < 2200000 || vco > 4400000) begin
         expected_words.push_back(make_word(0, 0, 1, ST_VCO));
         return;
      end
      pn = 64'(m_ref) * (1 + m_dbl);
      pd = 64'(m_rdiv == 0 ? 8'd1 : m_rdiv) * (1 + m_half);
      if (rq.spacing == 0) modv = 4095;
      else begin
         den = pd * rq.spacing;
         modv = (2 * pn + den) / (2 * den);
         if (modv > 4095) modv = 4095;
      end
      if (modv == 0) begin
         expected_words.push_back(make_word(0, 0, 1, ST_MOD));
         return;
      end
      num = vco * pd;
      nint = num / pn;
      rem = num % pn;
      frac = (2 * rem * modv + pn) / (2 * pn);
      if (frac >= modv) begin
         nint += frac / modv;
         frac %= modv;
      end
      n16 = nint[15:0];
      pre = n16 >= 75;
      lock = frac == 0;
      w[5] = 32'd5 | (32'd3 << 19) | (32'd1 << 22);
      w[4] = 32'd4 | (32'(m_power) << 3) | (32'(m_rfon) << 5) | (32'd200 << 12)
           | (32'(sel) << 20) | (32'd1 << 23);
      w[3] = 32'd3 | (32'd150 << 3);
      w[2] = 32'd2 | (32'd1 << 6) | (32'(lock) << 7) | (32'(lock) << 8)
           | (32'(m_pump) << 9) | (32'(m_rdiv) << 14) | (32'(m_half) << 24)
           | (32'(m_dbl) << 25);
      w[1] = 32'd1 | (32'(modv[11:0]) << 3) | (32'd1 << 15) | (32'(pre) << 27);
      w[0] = (32'(n16) << 15) | (32'(frac[11:0]) << 3);
      for (int k = 5; k >= 0; k--)
         expected_words.push_back(make_word(w[k], 3'(k), k == 0, ST_OK));
   endfunction

   // Driver: bursts and gaps; hold payload until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_words(pending_reqs.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_valid <= 1'b1;
               req_target_freq_khz <= pending_reqs[0].freq;
               req_spacing_khz <= pending_reqs[0].spacing;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: receiver stall pattern, long hold-off when asked, compare words.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_reg_word, 0);
            end else begin
               reg_word_type e;
               e = expected_words.pop_front();
               if (rsp_reg_word !== e.word) report_mismatch("reg_word", rsp_reg_word, e.word);
               if (rsp_reg_number !== e.num)
                  report_mismatch("reg_number", rsp_reg_number, e.num);
               if (rsp_last_word !== e.last)
                  report_mismatch("last_word", rsp_last_word, e.last);
               if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            end
         end
         if (long_stall_ask && !long_stall_taken) begin
            long_stall_taken <= 1'b1;
            hold_off <= 600;
            rsp_ready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0) || stimulus_done;
         end
      end
   end

   // Watchdog: stop when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [RefW-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_REF:   m_ref = value;
         CSR_RDIV:  m_rdiv = value[7:0];
         CSR_DBL:   m_dbl = value[0];
         CSR_HALF:  m_half = value[0];
         CSR_POWER: m_power = value[1:0];
         CSR_RFON:  m_rfon = value[0];
         default:   m_pump = value[3:0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic freq_req_type random_req();
      freq_req_type r;
      case ($urandom_range(0, 9))
         0: r.freq = FreqW'($urandom_range(0, (1 << 23) - 1));
         1: r.freq = FreqW'($urandom_range(0, 34999));
         2: r.freq = FreqW'($urandom_range(4400001, 8388607));
         default: r.freq = FreqW'($urandom_range(35000, 4400000));
      endcase
      case ($urandom_range(0, 7))
         0: r.spacing = SpW'($urandom_range(0, (1 << 17) - 1));
         1: r.spacing = SpW'($urandom_range(0, 3));
         2: r.spacing = SpW'($urandom_range(1, 100000));
         default: r.spacing = SpW'($urandom_range(1, 200));
      endcase
      // zero reference with zero spacing leaves N undefined; keep spacing nonzero
      if (m_ref == '0 && r.spacing == '0) r.spacing = 1;
      return r;
   endfunction

   task automatic push_req(logic [FreqW-1:0] f, logic [SpW-1:0] s);
      freq_req_type r;
      r.freq = f; r.spacing = s;
      pending_reqs.push_back(r);
   endtask

   initial begin
      m_ref = 25000; m_rdiv = 1; m_dbl = 0; m_half = 0;
      m_power = 3; m_rfon = 1; m_pump = 7;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: bounds, thresholds, errors, zero spacing, wide fields
      push_req(35000, 1);         push_req(34999, 1);
      push_req(4400000, 100);     push_req(4400001, 100);
      push_req(0, 1);             push_req(23'h7FFFFF, 17'h1FFFF);
      push_req(2200000, 0);       push_req(2199999, 25);
      push_req(1100000, 10);      push_req(550000, 1);
      push_req(275000, 7);        push_req(137500, 3);
      push_req(68750, 100000);    push_req(68749, 1);
      push_req(3000123, 17'h10000); push_req(1234567, 1);
      wait_drained();

      // several CSR settings, extremes included, random traffic each
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_REF, 250000); write_csr(CSR_RDIV, 255);
               write_csr(CSR_DBL, 1); write_csr(CSR_HALF, 0);
               write_csr(CSR_POWER, 0); write_csr(CSR_RFON, 0); write_csr(CSR_PUMP, 15);
            end
            1: begin
               write_csr(CSR_REF, 1); write_csr(CSR_RDIV, 1);
               write_csr(CSR_DBL, 0); write_csr(CSR_HALF, 1);
               write_csr(CSR_POWER, 2); write_csr(CSR_PUMP, 0);
            end
            2: begin
               write_csr(CSR_REF, 0); write_csr(CSR_RDIV, 0);
               write_csr(CSR_RFON, 1); write_csr(CSR_POWER, 1);
            end
            3: begin
               write_csr(CSR_REF, 18'h3FFFF); write_csr(CSR_RDIV, 0);
               write_csr(CSR_DBL, 1); write_csr(CSR_HALF, 1);
            end
            default: begin
               write_csr(CSR_REF, RefW'($urandom_range(1000, 250000)));
               write_csr(CSR_RDIV, RefW'($urandom_range(0, 255)));
               write_csr(CSR_DBL, RefW'($urandom_range(0, 1)));
               write_csr(CSR_HALF, RefW'($urandom_range(0, 1)));
               write_csr(CSR_POWER, RefW'($urandom_range(0, 3)));
               write_csr(CSR_RFON, RefW'($urandom_range(0, 1)));
               write_csr(CSR_PUMP, RefW'($urandom_range(0, 15)));
            end
         endcase
         if (phase == 2) begin
            // zero reference: every in-range item ends in the modulus error
            push_req(3000000, 1); push_req(100000, 5);
         end
         for (int k = 0; k < 22; k++) pending_reqs.push_back(random_req());
         // long receiver hold-off while the sender keeps offering
         if (phase == 1) long_stall_ask = 1;
         wait_drained();
      end

      stimulus_done = 1;
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
